// ===== rtl/core/tvc_pkg.sv =====
`default_nettype none

package tvc_pkg;

    // Value kinds
    localparam logic [1:0] KIND_BOOL   = 2'd0;
    localparam logic [1:0] KIND_INT    = 2'd1;
    localparam logic [1:0] KIND_DOUBLE = 2'd2;

    // Compare operations
    localparam logic [2:0] OP_EQ  = 3'd0;
    localparam logic [2:0] OP_NE  = 3'd1;
    localparam logic [2:0] OP_AEQ = 3'd2;
    localparam logic [2:0] OP_ANE = 3'd3;
    localparam logic [2:0] OP_LE  = 3'd4;
    localparam logic [2:0] OP_LT  = 3'd5;
    localparam logic [2:0] OP_GE  = 3'd6;
    localparam logic [2:0] OP_GT  = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    // Register indexes (byte address bits [4:3])
    localparam logic [1:0] REG_OPERATION = 2'd0;
    localparam logic [1:0] REG_REF_KIND  = 2'd1;
    localparam logic [1:0] REG_REF_BITS  = 2'd2;
    localparam logic [1:0] REG_TOLERANCE = 2'd3;

    // Exponent of an integer held with its binary point below bit 0
    localparam logic [10:0] EXP_INT = 11'd1075;

    // Unpacked operand: value = sig * 2^(expo - 1075); zero has expo 1
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        sgn;
        logic [10:0] expo;
        logic [52:0] sig;
    } operand_t;

    typedef struct packed {
        logic [2:0] op;
        logic       use_float;
        logic [1:0] status;
        logic       fixed_verdict;
        operand_t   a;
        operand_t   b;
    } stage_a_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        use_float;
        logic [1:0]  status;
        logic        fixed_verdict;
        logic        nan_res;
        logic        inf_res;
        logic        unord;
        logic        lt;
        logic        eq;
        logic        eff_sub;
        logic [10:0] exp_x;
        logic [55:0] sig_x;
        logic [55:0] sig_y;
    } stage_b_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        use_float;
        logic [1:0]  status;
        logic        fixed_verdict;
        logic        nan_res;
        logic        inf_res;
        logic        unord;
        logic        lt;
        logic        eq;
        logic [10:0] exp_x;
        logic [56:0] sum;
        logic [5:0]  lz;
    } stage_c_t;

    // Leading zero count over 64 bits, six halving steps
    function automatic logic [5:0] lzc64(input logic [63:0] x);
        logic [63:0] v;
        logic [5:0]  n;
        v = x;
        n = '0;
        if (v[63:32] == 32'h0)
        begin
            n[5] = 1'b1;
            v    = {v[31:0], 32'h0};
        end
        if (v[63:48] == 16'h0)
        begin
            n[4] = 1'b1;
            v    = {v[47:0], 16'h0};
        end
        if (v[63:56] == 8'h0)
        begin
            n[3] = 1'b1;
            v    = {v[55:0], 8'h0};
        end
        if (v[63:60] == 4'h0)
        begin
            n[2] = 1'b1;
            v    = {v[59:0], 4'h0};
        end
        if (v[63:62] == 2'h0)
        begin
            n[1] = 1'b1;
            v    = {v[61:0], 2'h0};
        end
        if (v[63] == 1'b0)
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tvc_decode.sv =====
`default_nettype none

module tvc_decode (
    input  wire logic [2:0]      op,
    input  wire logic [1:0]      ref_kind,
    input  wire logic [63:0]     ref_bits,
    input  wire logic [1:0]      sample_kind,
    input  wire logic [63:0]     sample_bits,
    output tvc_pkg::stage_a_t    stage
);
    import tvc_pkg::*;

    function automatic operand_t unpack_double(input logic [63:0] b);
        operand_t o;
        o.nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'h0);
        o.inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'h0);
        o.sgn  = b[63];
        o.expo = (b[62:52] == 11'h0) ? 11'd1 : b[62:52];
        o.sig  = {(b[62:52] != 11'h0), b[51:0]};
        return o;
    endfunction

    logic [63:0] ib;
    logic [63:0] imag;
    logic [63:0] dbits;
    logic [62:0] dmag;
    logic [5:0]  ilz;
    logic [52:0] ishift;
    logic        int_big;
    logic        dbl_nan;
    logic        dbl_big;
    logic        bool_v;
    logic        int_v;
    operand_t    iop;

    // Range checks for a mixed pair
    always_comb
    begin
        ib      = (sample_kind == KIND_INT) ? sample_bits : ref_bits;
        imag    = ib[63] ? (~ib + 64'd1) : ib;
        int_big = (ib == 64'h8000_0000_0000_0000) || (imag > 64'h0020_0000_0000_0000);
        dbits   = (sample_kind == KIND_DOUBLE) ? sample_bits : ref_bits;
        dmag    = dbits[62:0];
        dbl_nan = dmag > 63'h7FF0_0000_0000_0000;
        dbl_big = (dmag > 63'h4340_0000_0000_0000) && !dbl_nan;
    end

    // Integer operand normalised to double form
    always_comb
    begin
        ilz      = lzc64({imag[52:0], 11'h0});
        ishift   = imag[52:0] << ilz;
        iop.nan  = 1'b0;
        iop.inf  = 1'b0;
        iop.sgn  = ib[63];
        if (imag[53])
        begin
            iop.expo = EXP_INT + 11'd1;
            iop.sig  = imag[53:1];
        end
        else if (imag[52:0] == 53'h0)
        begin
            iop.expo = 11'd1;
            iop.sig  = '0;
        end
        else
        begin
            iop.expo = EXP_INT - {5'h0, ilz};
            iop.sig  = ishift;
        end
    end

    // Bool and integer verdicts
    always_comb
    begin
        bool_v = (op == OP_EQ) ? (sample_bits[0] == ref_bits[0])
                               : (sample_bits[0] != ref_bits[0]);
        case (op)
            OP_EQ:   int_v = sample_bits == ref_bits;
            OP_NE:   int_v = sample_bits != ref_bits;
            OP_LE:   int_v = $signed(sample_bits) <= $signed(ref_bits);
            OP_LT:   int_v = $signed(sample_bits) <  $signed(ref_bits);
            OP_GE:   int_v = $signed(sample_bits) >= $signed(ref_bits);
            OP_GT:   int_v = $signed(sample_bits) >  $signed(ref_bits);
            default: int_v = 1'b0;
        endcase
    end

    // Status and operand selection
    always_comb
    begin
        stage.op            = op;
        // float path only when a double is involved; bool and int pairs use the fixed verdict
        stage.use_float     = (sample_kind == KIND_DOUBLE) || (ref_kind == KIND_DOUBLE);
        stage.fixed_verdict = (sample_kind == KIND_BOOL) ? bool_v : int_v;
        stage.a = (sample_kind == KIND_INT) ? iop : unpack_double(sample_bits);
        stage.b = (ref_kind == KIND_INT) ? iop : unpack_double(ref_bits);

        if ((sample_kind > KIND_DOUBLE) || (ref_kind > KIND_DOUBLE))
            stage.status = ST_INVALID;
        else if ((sample_kind == KIND_BOOL) || (ref_kind == KIND_BOOL))
            stage.status = ((sample_kind == ref_kind) && (op == OP_EQ || op == OP_NE))
                           ? ST_OK : ST_INVALID;
        else if ((sample_kind == KIND_INT) && (ref_kind == KIND_INT))
            stage.status = (op == OP_AEQ || op == OP_ANE) ? ST_INVALID : ST_OK;
        else if (op == OP_EQ || op == OP_NE)
            stage.status = ST_INVALID;
        else if (sample_kind == ref_kind)
            stage.status = ST_OK;
        else if (dbl_big || int_big)
            stage.status = ST_RANGE;
        else
            stage.status = ST_OK;
    end

endmodule

`default_nettype wire

// ===== rtl/core/tvc_align.sv =====
`default_nettype none

module tvc_align (
    input  tvc_pkg::stage_a_t in_stage,
    output tvc_pkg::stage_b_t out_stage
);
    import tvc_pkg::*;

    operand_t    x;
    operand_t    y;
    logic        mag_gt;
    logic        mag_eq;
    logic        a_zero;
    logic        b_zero;
    logic        eff_sub;
    logic [10:0] d;
    logic [5:0]  sh;
    logic [55:0] yext;
    logic [55:0] shifted;
    logic        lost;

    always_comb
    begin
        // Ordering from signs and magnitudes
        mag_gt  = {in_stage.a.expo, in_stage.a.sig} > {in_stage.b.expo, in_stage.b.sig};
        mag_eq  = {in_stage.a.expo, in_stage.a.sig} == {in_stage.b.expo, in_stage.b.sig};
        a_zero  = !in_stage.a.inf && (in_stage.a.expo == 11'd1) && (in_stage.a.sig == 53'h0);
        b_zero  = !in_stage.b.inf && (in_stage.b.expo == 11'd1) && (in_stage.b.sig == 53'h0);
        eff_sub = in_stage.a.sgn == in_stage.b.sgn;

        out_stage.op            = in_stage.op;
        out_stage.use_float     = in_stage.use_float;
        out_stage.status        = in_stage.status;
        out_stage.fixed_verdict = in_stage.fixed_verdict;
        out_stage.unord         = in_stage.a.nan || in_stage.b.nan;
        out_stage.nan_res       = out_stage.unord
                                  || (in_stage.a.inf && in_stage.b.inf && eff_sub);
        out_stage.inf_res       = in_stage.a.inf || in_stage.b.inf;
        out_stage.eff_sub       = eff_sub;
        if (eff_sub)
        begin
            out_stage.eq = mag_eq;
            out_stage.lt = in_stage.a.sgn ? mag_gt : (!mag_eq && !mag_gt);
        end
        else
        begin
            out_stage.eq = a_zero && b_zero;
            out_stage.lt = !(a_zero && b_zero) && in_stage.a.sgn;
        end

        // Swap so the larger magnitude leads, then align the smaller with sticky
        x       = mag_gt ? in_stage.a : in_stage.b;
        y       = mag_gt ? in_stage.b : in_stage.a;
        d       = x.expo - y.expo;
        sh      = (d > 11'd56) ? 6'd56 : d[5:0];
        yext    = {y.sig, 3'b000};
        shifted = yext >> sh;
        lost    = |(yext & ~({56{1'b1}} << sh));

        out_stage.exp_x = x.expo;
        out_stage.sig_x = {x.sig, 3'b000};
        out_stage.sig_y = {shifted[55:1], shifted[0] | lost};
    end

endmodule

`default_nettype wire

// ===== rtl/core/tvc_sum.sv =====
`default_nettype none

module tvc_sum (
    input  tvc_pkg::stage_b_t in_stage,
    output tvc_pkg::stage_c_t out_stage
);
    import tvc_pkg::*;

    logic [56:0] sum;

    // Magnitude add or subtract, then leading zero count for normalisation
    always_comb
    begin
        sum = in_stage.eff_sub ? ({1'b0, in_stage.sig_x} - {1'b0, in_stage.sig_y})
                               : ({1'b0, in_stage.sig_x} + {1'b0, in_stage.sig_y});

        out_stage.op            = in_stage.op;
        out_stage.use_float     = in_stage.use_float;
        out_stage.status        = in_stage.status;
        out_stage.fixed_verdict = in_stage.fixed_verdict;
        out_stage.nan_res       = in_stage.nan_res;
        out_stage.inf_res       = in_stage.inf_res;
        out_stage.unord         = in_stage.unord;
        out_stage.lt            = in_stage.lt;
        out_stage.eq            = in_stage.eq;
        out_stage.exp_x         = in_stage.exp_x;
        out_stage.sum           = sum;
        out_stage.lz            = lzc64({sum[55:0], 8'h0});
    end

endmodule

`default_nettype wire

// ===== rtl/core/tvc_round.sv =====
`default_nettype none

module tvc_round (
    input  tvc_pkg::stage_c_t in_stage,
    input  wire logic [63:0]  tolerance,
    output logic              verdict,
    output logic [1:0]        status
);
    import tvc_pkg::*;

    logic [11:0] limit;
    logic [5:0]  shl;
    logic [55:0] norm;
    logic [11:0] e;
    logic [11:0] e2;
    logic        up;
    logic [53:0] mr;
    logic [52:0] mant;
    logic [10:0] efield;
    logic [62:0] rmag;
    logic        tol_nan;
    logic        in_tol;
    logic        v;

    // Normalise, round to nearest even and pack |a - b|
    always_comb
    begin
        limit = {1'b0, in_stage.exp_x} - 12'd1;
        shl   = ({6'h0, in_stage.lz} < limit) ? in_stage.lz : limit[5:0];
        if (in_stage.sum[56])
        begin
            norm = {in_stage.sum[56:2], in_stage.sum[1] | in_stage.sum[0]};
            e    = {1'b0, in_stage.exp_x} + 12'd1;
        end
        else
        begin
            norm = in_stage.sum[55:0] << shl;
            e    = {1'b0, in_stage.exp_x} - {6'h0, shl};
        end
        up = norm[2] && (norm[1] || norm[0] || norm[3]);
        mr = {1'b0, norm[55:3]} + {53'h0, up};
        if (mr[53])
        begin
            mant = mr[53:1];
            e2   = e + 12'd1;
        end
        else
        begin
            mant = mr[52:0];
            e2   = e;
        end
        efield = mant[52] ? e2[10:0] : 11'h0;
        if (in_stage.inf_res || (mant[52] && (e2 >= 12'd2047)))
            rmag = {11'h7FF, 52'h0};
        else
            rmag = {efield, mant[51:0]};
    end

    // Tolerance compare and final verdict
    always_comb
    begin
        tol_nan = tolerance[62:0] > 63'h7FF0_0000_0000_0000;
        if (tol_nan)
            in_tol = 1'b0;
        else if (tolerance[63])
            in_tol = (rmag == 63'h0) && (tolerance[62:0] == 63'h0);
        else
            in_tol = rmag <= tolerance[62:0];

        case (in_stage.op)
            OP_AEQ:  v = !in_stage.nan_res && in_tol;
            OP_ANE:  v = !in_stage.nan_res && !tol_nan && !in_tol;
            OP_LE:   v = !in_stage.unord && (in_stage.lt || in_stage.eq);
            OP_LT:   v = !in_stage.unord && in_stage.lt;
            OP_GE:   v = !in_stage.unord && !in_stage.lt;
            OP_GT:   v = !in_stage.unord && !in_stage.lt && !in_stage.eq;
            default: v = 1'b0;
        endcase

        status  = in_stage.status;
        verdict = (in_stage.status == ST_OK)
                  && (in_stage.use_float ? v : in_stage.fixed_verdict);
    end

endmodule

`default_nettype wire

// ===== rtl/core/typed_value_comparator.sv =====
`default_nettype none

// Channel   Handshake                     Payload
// sample    sample_valid / sample_ready   sample_kind, sample_bits
// result    result_valid / result_ready   verdict, status
// config    APB psel/penable/pwrite       paddr, pwdata, prdata (64-bit regs at 8*i)
//
// Four register stages: decode, align, add, round/output. A sample passes through
// them in that order; one transaction per cycle sustained while result_ready holds.
// Each stage moves on when the stage after it is empty or moving, so empty
// stages keep filling while a result waits on result_ready.
// rst_n clears the valid bits and the configuration registers.

module typed_value_comparator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        sample_valid,
    output logic             sample_ready,
    input  wire logic [1:0]  sample_kind,
    input  wire logic [63:0] sample_bits,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             verdict,
    output logic [1:0]       status
);
    import tvc_pkg::*;

    logic [2:0]  operation_reg;
    logic [1:0]  ref_kind_reg;
    logic [63:0] ref_bits_reg;
    logic [63:0] tolerance_reg;

    logic        va_reg;
    logic        vb_reg;
    logic        vc_reg;
    logic        vd_reg;
    logic        take_a;
    logic        take_b;
    logic        take_c;
    logic        take_d;

    stage_a_t    a_next;
    stage_a_t    a_reg;
    stage_b_t    b_next;
    stage_b_t    b_reg;
    stage_c_t    c_next;
    stage_c_t    c_reg;
    logic        verdict_next;
    logic [1:0]  status_next;
    logic        verdict_reg;
    logic [1:0]  status_reg;

    // Configuration registers
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= '0;
            ref_kind_reg  <= '0;
            ref_bits_reg  <= '0;
            tolerance_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[4:3])
                REG_OPERATION: operation_reg <= pwdata[2:0];
                REG_REF_KIND:  ref_kind_reg  <= pwdata[1:0];
                REG_REF_BITS:  ref_bits_reg  <= pwdata;
                REG_TOLERANCE: tolerance_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_OPERATION: prdata = {61'h0, operation_reg};
            REG_REF_KIND:  prdata = {62'h0, ref_kind_reg};
            REG_REF_BITS:  prdata = ref_bits_reg;
            REG_TOLERANCE: prdata = tolerance_reg;
            default:       prdata = '0;
        endcase
    end

    // Stage advance
    assign take_d       = !vd_reg || result_ready;
    assign take_c       = !vc_reg || take_d;
    assign take_b       = !vb_reg || take_c;
    assign take_a       = !va_reg || take_b;
    assign sample_ready = take_a;
    assign result_valid = vd_reg;
    assign verdict      = verdict_reg;
    assign status       = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (take_a)
                va_reg <= sample_valid;
            if (take_b)
                vb_reg <= va_reg;
            if (take_c)
                vc_reg <= vb_reg;
            if (take_d)
                vd_reg <= vc_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (take_a)
            a_reg <= a_next;
        if (take_b)
            b_reg <= b_next;
        if (take_c)
            c_reg <= c_next;
        if (take_d)
        begin
            verdict_reg <= verdict_next;
            status_reg  <= status_next;
        end
    end

    tvc_decode u_decode (
        .op          (operation_reg),
        .ref_kind    (ref_kind_reg),
        .ref_bits    (ref_bits_reg),
        .sample_kind (sample_kind),
        .sample_bits (sample_bits),
        .stage       (a_next)
    );

    tvc_align u_align (
        .in_stage  (a_reg),
        .out_stage (b_next)
    );

    tvc_sum u_sum (
        .in_stage  (b_reg),
        .out_stage (c_next)
    );

    tvc_round u_round (
        .in_stage  (c_reg),
        .tolerance (tolerance_reg),
        .verdict   (verdict_next),
        .status    (status_next)
    );

endmodule

`default_nettype wire
